[rtl/mbdt_pkg.sv]
// Package for the Modbus slave data table engine.
// Holds request codes and state machine encoding; no dependencies.
package mbdt_pkg;

    typedef enum logic [3:0] {
        REQ_RD_COILS    = 4'd0,
        REQ_RD_DISCRETE = 4'd1,
        REQ_RD_HOLDING  = 4'd2,
        REQ_RD_INPUT    = 4'd3,
        REQ_WR_COIL     = 4'd4,
        REQ_WR_REG      = 4'd5,
        REQ_WR_MULTI    = 4'd6,
        REQ_LD_DISCRETE = 4'd7,
        REQ_LD_INPUT    = 4'd8
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_RD_EMIT,
        ST_WR_READ,
        ST_WR_MOD,
        ST_OUT
    } state_t;

endpackage

[rtl/modbus_slave_data_table_engine_unit.sv]
// Modbus slave data table engine: top level with all four tables.
// Depends on mbdt_pkg.
//
// Usage: a decoded request enters on the s_ channel (valid/ready). Reads
// return one item per packed coil or discrete byte or register word on the m_ channel,
// with m_last on the final one. Writes, loads and errors return one item;
// a non-final element of a multi-register write returns none.
// Bit tables are stored as one bit per memory word. After an ST_RD_ISSUE setup
// state, a bit read passes the bits one at a time through one read port,
// through ST_RD_WAIT then ST_RD_EMIT for each bit, up to eight per returned byte.
// A register read passes ST_RD_WAIT then ST_RD_EMIT for each word, and a write
// passes ST_WR_READ (range check), ST_WR_MOD (memory write) and ST_OUT.
// After reset the block sweeps the memories to zero, one entry per cycle,
// up to the largest of COIL_BITS, DISCRETE_BITS, HOLDING_REGS and INPUT_REGS,
// and accepts no item meanwhile. When the receiver stalls the result holds
// in the output register and the engine waits.
module modbus_slave_data_table_engine_unit
    import mbdt_pkg::*;
#(
    parameter int COIL_BITS      = 1024,
    parameter int DISCRETE_BITS  = 1024,
    parameter int HOLDING_REGS   = 256,
    parameter int INPUT_REGS     = 256,
    parameter int MAX_READ_ITEMS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_req_type,
    input  logic [7:0]  s_unit_id,
    input  logic [15:0] s_start_addr,
    input  logic [15:0] s_quantity,
    input  logic [15:0] s_write_value,
    input  logic [6:0]  s_elem_index,
    input  logic        s_elem_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_resp_unit,
    output logic [3:0]  m_resp_type,
    output logic [7:0]  m_byte_count,
    output logic [15:0] m_data_word,
    output logic [15:0] m_echo_addr,
    output logic [15:0] m_echo_field,
    output logic        m_status,
    output logic        m_last
);

    localparam int CW = (COIL_BITS > 1) ? $clog2(COIL_BITS) : 1;
    localparam int DW = (DISCRETE_BITS > 1) ? $clog2(DISCRETE_BITS) : 1;
    localparam int HW = (HOLDING_REGS > 1) ? $clog2(HOLDING_REGS) : 1;
    localparam int IW = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;
    localparam int M1 = COIL_BITS > DISCRETE_BITS ? COIL_BITS : DISCRETE_BITS;
    localparam int M2 = HOLDING_REGS > INPUT_REGS ? HOLDING_REGS : INPUT_REGS;
    localparam int MAXD = M1 > M2 ? M1 : M2;
    localparam logic [16:0] LIM_BITS = 17'(8 * MAX_READ_ITEMS);
    localparam logic [16:0] LIM_REGS = 17'(MAX_READ_ITEMS);

    logic coil_mem [COIL_BITS];
    logic disc_mem [DISCRETE_BITS];
    logic [15:0] hold_mem [HOLDING_REGS];
    logic [15:0] inp_mem [INPUT_REGS];

    state_t state_reg, state_next;
    logic [16:0] clr_reg, clr_next;
    logic [3:0]  typ_reg, typ_next;
    logic [7:0]  unit_reg, unit_next;
    logic [15:0] s_reg, s_next;
    logic [15:0] q_reg, q_next;
    logic [15:0] wv_reg, wv_next;
    logic [15:0] ea_reg, ea_next;
    logic [16:0] off_reg, off_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  acc_reg, acc_next;
    logic [7:0]  bc_reg, bc_next;
    logic [16:0] ra_reg, ra_next;
    logic        ok_reg, ok_next;
    logic        s_elem_last_reg;

    logic        out_v_reg, out_v_next;
    logic [7:0]  o_un_reg, o_un_next;
    logic [3:0]  o_ty_reg, o_ty_next;
    logic [7:0]  o_bc_reg, o_bc_next;
    logic [15:0] o_dw_reg, o_dw_next;
    logic [15:0] o_ea_reg, o_ea_next;
    logic [15:0] o_ef_reg, o_ef_next;
    logic        o_st_reg, o_st_next;
    logic        o_ls_reg, o_ls_next;

    logic        coil_rd, disc_rd;
    logic [15:0] hold_rd, inp_rd;

    logic        we_c, we_d, we_h, we_i, wbit;
    logic [16:0] wa;
    logic [15:0] wword;

    logic [16:0] s_ext, q_ext, sum_q;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_v_reg;
    assign m_resp_unit = o_un_reg;
    assign m_resp_type = o_ty_reg;
    assign m_byte_count = o_bc_reg;
    assign m_data_word = o_dw_reg;
    assign m_echo_addr = o_ea_reg;
    assign m_echo_field = o_ef_reg;
    assign m_status = o_st_reg;
    assign m_last = o_ls_reg;

    assign s_ext = {1'b0, s_reg};
    assign q_ext = {1'b0, q_reg};
    assign sum_q = s_ext + q_ext;

    always_ff @(posedge aclk) begin
        coil_rd <= coil_mem[ra_reg[CW-1:0]];
        disc_rd <= disc_mem[ra_reg[DW-1:0]];
        hold_rd <= hold_mem[ra_reg[HW-1:0]];
        inp_rd  <= inp_mem[ra_reg[IW-1:0]];
        if (we_c) coil_mem[wa[CW-1:0]] <= wbit;
        if (we_d) disc_mem[wa[DW-1:0]] <= wbit;
        if (we_h) hold_mem[wa[HW-1:0]] <= wword;
        if (we_i) inp_mem[wa[IW-1:0]] <= wword;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_v_reg <= out_v_next;
        end
        typ_reg <= typ_next; unit_reg <= unit_next; s_reg <= s_next;
        q_reg <= q_next; wv_reg <= wv_next; ea_reg <= ea_next;
        off_reg <= off_next; bit_reg <= bit_next; acc_reg <= acc_next;
        bc_reg <= bc_next; ra_reg <= ra_next; ok_reg <= ok_next;
        o_un_reg <= o_un_next; o_ty_reg <= o_ty_next;
        o_bc_reg <= o_bc_next; o_dw_reg <= o_dw_next; o_ea_reg <= o_ea_next;
        o_ef_reg <= o_ef_next; o_st_reg <= o_st_next; o_ls_reg <= o_ls_next;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) s_elem_last_reg <= s_elem_last;
    end

    always_comb begin
        logic rbit;
        logic [16:0] nb;
        logic emit_v;
        state_next = state_reg; clr_next = clr_reg;
        typ_next = typ_reg; unit_next = unit_reg; s_next = s_reg;
        q_next = q_reg; wv_next = wv_reg; ea_next = ea_reg;
        off_next = off_reg; bit_next = bit_reg; acc_next = acc_reg;
        bc_next = bc_reg; ra_next = ra_reg; ok_next = ok_reg;
        out_v_next = out_v_reg && !m_ready;
        o_un_next = o_un_reg; o_ty_next = o_ty_reg;
        o_bc_next = o_bc_reg; o_dw_next = o_dw_reg; o_ea_next = o_ea_reg;
        o_ef_next = o_ef_reg; o_st_next = o_st_reg; o_ls_next = o_ls_reg;
        we_c = 1'b0; we_d = 1'b0; we_h = 1'b0; we_i = 1'b0;
        wbit = 1'b0; wa = clr_reg; wword = '0;
        rbit = (typ_reg == REQ_RD_COILS || typ_reg == REQ_WR_COIL) ? coil_rd : disc_rd;
        nb = (q_ext + 17'd7) >> 3;
        emit_v = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                we_c = clr_reg < 17'(COIL_BITS);
                we_d = clr_reg < 17'(DISCRETE_BITS);
                we_h = clr_reg < 17'(HOLDING_REGS);
                we_i = clr_reg < 17'(INPUT_REGS);
                clr_next = clr_reg + 17'd1;
                if (clr_reg == 17'(MAXD - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    typ_next = s_req_type; unit_next = s_unit_id;
                    s_next = s_start_addr; q_next = s_quantity;
                    wv_next = s_write_value;
                    ea_next = s_start_addr + {9'd0, s_elem_index};
                    off_next = '0; bit_next = '0; acc_next = '0;
                    ra_next = {1'b0, s_start_addr};
                    ok_next = 1'b0;
                    unique case (s_req_type) inside
                        REQ_RD_COILS, REQ_RD_DISCRETE, REQ_RD_HOLDING, REQ_RD_INPUT:
                            state_next = ST_RD_ISSUE;
                        REQ_WR_COIL, REQ_WR_REG, REQ_WR_MULTI, REQ_LD_DISCRETE,
                        REQ_LD_INPUT:
                            state_next = ST_WR_READ;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_RD_ISSUE: begin
                if (typ_reg == REQ_RD_COILS || typ_reg == REQ_RD_DISCRETE) begin
                    ok_next = q_reg != 0 && q_ext <= LIM_BITS &&
                        sum_q <= 17'(typ_reg == REQ_RD_COILS ? COIL_BITS : DISCRETE_BITS);
                    bc_next = nb[7:0];
                end else begin
                    ok_next = q_reg != 0 && q_ext <= LIM_REGS &&
                        sum_q <= 17'(typ_reg == REQ_RD_HOLDING ? HOLDING_REGS : INPUT_REGS);
                    bc_next = 8'(q_ext << 1);
                end
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                if (!ok_reg) state_next = ST_OUT;
                else state_next = ST_RD_EMIT;
            end
            ST_RD_EMIT: begin
                if (!out_v_reg || m_ready) begin
                    if (typ_reg == REQ_RD_HOLDING || typ_reg == REQ_RD_INPUT) begin
                        emit_v = 1'b1;
                        o_dw_next = typ_reg == REQ_RD_HOLDING ? hold_rd : inp_rd;
                        o_ls_next = off_reg + 17'd1 == q_ext;
                        off_next = off_reg + 17'd1;
                        ra_next = ra_reg + 17'd1;
                        state_next = o_ls_next ? ST_IDLE : ST_RD_WAIT;
                    end else begin
                        acc_next = acc_reg | ({7'd0, rbit} << bit_reg);
                        off_next = off_reg + 17'd1;
                        ra_next = ra_reg + 17'd1;
                        bit_next = bit_reg + 3'd1;
                        if (bit_reg == 3'd7 || off_reg + 17'd1 == q_ext) begin
                            emit_v = 1'b1;
                            o_dw_next = {8'd0, acc_next};
                            o_ls_next = off_reg + 17'd1 == q_ext;
                            acc_next = '0; bit_next = '0;
                            state_next = o_ls_next ? ST_IDLE : ST_RD_WAIT;
                        end else state_next = ST_RD_WAIT;
                    end
                    if (emit_v) begin
                        out_v_next = 1'b1; o_bc_next = bc_reg;
                        o_un_next = unit_reg; o_ty_next = typ_reg;
                        o_ea_next = '0; o_ef_next = '0; o_st_next = 1'b0;
                    end
                end
            end
            ST_WR_READ: begin
                unique case (typ_reg)
                    REQ_WR_COIL:     ok_next = s_ext < 17'(COIL_BITS);
                    REQ_LD_DISCRETE: ok_next = s_ext < 17'(DISCRETE_BITS);
                    REQ_WR_REG:      ok_next = s_ext < 17'(HOLDING_REGS);
                    REQ_LD_INPUT:    ok_next = s_ext < 17'(INPUT_REGS);
                    default: ok_next = q_reg != 0 && {1'b0, ea_reg - s_reg} < q_ext &&
                        sum_q <= 17'(HOLDING_REGS);
                endcase
                state_next = ST_WR_MOD;
            end
            ST_WR_MOD: begin
                wbit = wv_reg != 0; wword = wv_reg;
                wa = typ_reg == REQ_WR_MULTI ? {1'b0, ea_reg} : s_ext;
                we_c = ok_reg && typ_reg == REQ_WR_COIL;
                we_d = ok_reg && typ_reg == REQ_LD_DISCRETE;
                we_h = ok_reg && (typ_reg == REQ_WR_REG || typ_reg == REQ_WR_MULTI);
                we_i = ok_reg && typ_reg == REQ_LD_INPUT;
                state_next = (typ_reg == REQ_WR_MULTI && !s_elem_last_reg) ? ST_IDLE
                                                                          : ST_OUT;
            end
            ST_OUT: begin
                if (!out_v_reg || m_ready) begin
                    out_v_next = 1'b1; o_bc_next = '0; o_dw_next = '0;
                    o_un_next = unit_reg; o_ty_next = typ_reg;
                    o_st_next = !ok_reg; o_ls_next = 1'b1;
                    o_ea_next = ok_reg ? s_reg : 16'd0;
                    o_ef_next = !ok_reg ? 16'd0 : (typ_reg == REQ_WR_MULTI ? q_reg : wv_reg);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready) else $error("accept during clear");
    a_err_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last && m_data_word == 16'd0 && m_byte_count == 8'd0)
        else $error("error item carries data");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_word))
        else $error("output changed under stall");
`endif

endmodule

[tb/sv/tb_modbus_slave_data_table_engine_unit.sv]
// Testbench for the Modbus slave data table engine: directed table, then random requests.
// Keeps its own copy of the four tables to predict every response item.
// Depends on mbdt_pkg and modbus_slave_data_table_engine_unit.
`timescale 1ns / 100ps

module tb_modbus_slave_data_table_engine_unit;
    import mbdt_pkg::*;

    localparam int NCOIL = 1024;
    localparam int NDISC = 1024;
    localparam int NHOLD = 256;
    localparam int NINP  = 256;
    localparam int MAXRD = 64;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  unit;
        logic [15:0] addr;
        logic [15:0] qty;
        logic [15:0] value;
        logic [6:0]  idx;
        logic        fin;
    } request_t;

    typedef struct packed {
        logic [7:0]  unit;
        logic [3:0]  kind;
        logic [7:0]  nbytes;
        logic [15:0] data;
        logic [15:0] eaddr;
        logic [15:0] efield;
        logic        status;
        logic        fin;
    } response_t;

    typedef struct packed {
        request_t  req;
        logic      known;
        response_t resp;
    } table_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_req_type = '0;
    logic [7:0]  s_unit_id = '0;
    logic [15:0] s_start_addr = '0;
    logic [15:0] s_quantity = '0;
    logic [15:0] s_write_value = '0;
    logic [6:0]  s_elem_index = '0;
    logic        s_elem_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_resp_unit;
    logic [3:0]  m_resp_type;
    logic [7:0]  m_byte_count;
    logic [15:0] m_data_word;
    logic [15:0] m_echo_addr;
    logic [15:0] m_echo_field;
    logic        m_status;
    logic        m_last;

    modbus_slave_data_table_engine_unit u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic      coil_bits [NCOIL];
    logic      disc_bits [NDISC];
    logic [15:0] hold_regs [NHOLD];
    logic [15:0] inp_regs [NINP];
    response_t pending_resp[$];
    int        mismatch_count = 0;
    int        resp_count = 0;
    int        req_count = 0;
    int        send_idle = 0;
    int        recv_idle = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic response_t error_resp(request_t r);
        response_t e;
        e = '0;
        e.unit = r.unit;
        e.kind = r.kind;
        e.status = 1'b1;
        e.fin = 1'b1;
        return e;
    endfunction

    task automatic predict_table_access(input request_t r);
        response_t e;
        int nb, s, q, size;
        bit ok;
        logic [7:0] byte_v;
        s = r.addr;
        q = r.qty;
        e = '0;
        e.unit = r.unit;
        e.kind = r.kind;
        case (r.kind)
            REQ_RD_COILS, REQ_RD_DISCRETE: begin
                size = (r.kind == REQ_RD_COILS) ? NCOIL : NDISC;
                if (q == 0 || q > 8 * MAXRD || s + q > size) begin
                    pending_resp.push_back(error_resp(r));
                end else begin
                    nb = (q + 7) / 8;
                    for (int k = 0; k < nb; k++) begin
                        byte_v = '0;
                        for (int j = 0; j < 8; j++)
                            if (8 * k + j < q)
                                byte_v[j] = (r.kind == REQ_RD_COILS) ?
                                    coil_bits[s + 8 * k + j] : disc_bits[s + 8 * k + j];
                        e.nbytes = 8'(nb);
                        e.data = {8'h00, byte_v};
                        e.fin = (k + 1 == nb);
                        pending_resp.push_back(e);
                    end
                end
            end
            REQ_RD_HOLDING, REQ_RD_INPUT: begin
                size = (r.kind == REQ_RD_HOLDING) ? NHOLD : NINP;
                if (q == 0 || q > MAXRD || s + q > size) begin
                    pending_resp.push_back(error_resp(r));
                end else begin
                    for (int k = 0; k < q; k++) begin
                        e.nbytes = 8'(2 * q);
                        e.data = (r.kind == REQ_RD_HOLDING) ? hold_regs[s + k] : inp_regs[s + k];
                        e.fin = (k + 1 == q);
                        pending_resp.push_back(e);
                    end
                end
            end
            REQ_WR_MULTI: begin
                ok = q != 0 && r.idx < q && s + q <= NHOLD;
                if (ok)
                    hold_regs[s + r.idx] = r.value;
                if (r.fin) begin
                    if (ok) begin
                        e.eaddr = r.addr;
                        e.efield = r.qty;
                        e.fin = 1'b1;
                        pending_resp.push_back(e);
                    end else begin
                        pending_resp.push_back(error_resp(r));
                    end
                end
            end
            default: begin
                ok = 1'b0;
                if (r.kind == REQ_WR_COIL && s < NCOIL) begin
                    coil_bits[s] = r.value != 0;
                    ok = 1'b1;
                end else if (r.kind == REQ_WR_REG && s < NHOLD) begin
                    hold_regs[s] = r.value;
                    ok = 1'b1;
                end else if (r.kind == REQ_LD_DISCRETE && s < NDISC) begin
                    disc_bits[s] = r.value != 0;
                    ok = 1'b1;
                end else if (r.kind == REQ_LD_INPUT && s < NINP) begin
                    inp_regs[s] = r.value;
                    ok = 1'b1;
                end
                if (ok) begin
                    e.eaddr = r.addr;
                    e.efield = r.value;
                    e.fin = 1'b1;
                    pending_resp.push_back(e);
                end else begin
                    pending_resp.push_back(error_resp(r));
                end
            end
        endcase
    endtask

    task automatic send_request(input request_t r);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_req_type, s_unit_id, s_start_addr, s_quantity, s_write_value,
         s_elem_index, s_elem_last} <= r;
        do @(posedge aclk); while (!s_ready);
        predict_table_access(r);
        req_count++;
    endtask

    task automatic send_checked(input table_row_t row);
        int before_n;
        before_n = pending_resp.size();
        send_request(row.req);
        if (row.known && pending_resp.size() > before_n
            && pending_resp[pending_resp.size() - 1] != row.resp)
            report_mismatch("table row expectation", req_count, 0);
    endtask

    always @(posedge aclk) begin
        response_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_resp_unit, m_resp_type, m_byte_count, m_data_word,
                       m_echo_addr, m_echo_field, m_status, m_last};
                resp_count++;
                if (pending_resp.size() == 0) begin
                    report_mismatch("unexpected response item", got.kind, 0);
                end else begin
                    want = pending_resp.pop_front();
                    if (got.unit != want.unit) report_mismatch("resp_unit", got.unit, want.unit);
                    if (got.kind != want.kind) report_mismatch("resp_type", got.kind, want.kind);
                    if (got.nbytes != want.nbytes)
                        report_mismatch("byte_count", got.nbytes, want.nbytes);
                    if (got.data != want.data) report_mismatch("data_word", got.data, want.data);
                    if (got.eaddr != want.eaddr)
                        report_mismatch("echo_addr", got.eaddr, want.eaddr);
                    if (got.efield != want.efield)
                        report_mismatch("echo_field", got.efield, want.efield);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.fin != want.fin) report_mismatch("last", got.fin, want.fin);
                end
            end
            m_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
        end
    end

    function automatic table_row_t row(input logic [3:0] k, input logic [15:0] a,
                                       input logic [15:0] q, input logic [15:0] v,
                                       input logic [6:0] i, input logic f,
                                       input logic known, input logic st,
                                       input logic [15:0] ea, input logic [15:0] ef);
        table_row_t t;
        t.req = '{kind: k, unit: 8'hA5, addr: a, qty: q, value: v, idx: i, fin: f};
        t.known = known;
        t.resp = '{unit: 8'hA5, kind: k, nbytes: 8'd0, data: 16'd0,
                   eaddr: ea, efield: ef, status: st, fin: 1'b1};
        return t;
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.unit = 8'($urandom);
        r.value = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF)
                                           : 16'($urandom);
        r.idx = 7'($urandom_range(7));
        r.fin = 1'($urandom_range(1));
        r.kind = 4'($urandom_range(8));
        if ($urandom_range(15) == 0) r.kind = 4'($urandom_range(15, 9));
        case ($urandom_range(9))
            0: r.addr = 16'($urandom);
            1: r.addr = 16'(16'hFFFF - $urandom_range(3));
            default: r.addr = (r.kind inside {REQ_RD_COILS, REQ_RD_DISCRETE, REQ_WR_COIL,
                                              REQ_LD_DISCRETE}) ? 16'($urandom_range(1023))
                                                                : 16'($urandom_range(255));
        endcase
        case ($urandom_range(9))
            0: r.qty = 16'($urandom);
            1: r.qty = '0;
            default: r.qty = (r.kind inside {REQ_RD_COILS, REQ_RD_DISCRETE})
                             ? 16'($urandom_range(1, 40)) : 16'($urandom_range(1, 8));
        endcase
        return r;
    endfunction

    initial begin
        table_row_t dir [$];
        request_t r;
        int n_multi, base;
        for (int i = 0; i < NCOIL; i++) begin
            coil_bits[i] = 1'b0;
            disc_bits[i] = 1'b0;
        end
        for (int i = 0; i < NHOLD; i++) begin
            hold_regs[i] = '0;
            inp_regs[i] = '0;
        end
        dir.push_back(row(REQ_RD_COILS, 0, 0, 0, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_RD_COILS, 1020, 5, 0, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_RD_COILS, 0, 513, 0, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_RD_HOLDING, 0, 65, 0, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_RD_INPUT, 255, 2, 0, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_WR_COIL, 1023, 0, 16'hFFFF, 0, 0, 1, 0, 1023, 16'hFFFF));
        dir.push_back(row(REQ_WR_COIL, 3, 0, 1, 0, 0, 1, 0, 3, 1));
        dir.push_back(row(REQ_WR_COIL, 1024, 0, 1, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_LD_DISCRETE, 0, 0, 5, 0, 0, 1, 0, 0, 5));
        dir.push_back(row(REQ_LD_DISCRETE, 16'hFFFF, 0, 5, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_WR_REG, 255, 0, 16'hBEEF, 0, 0, 1, 0, 255, 16'hBEEF));
        dir.push_back(row(REQ_WR_REG, 256, 0, 1, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_LD_INPUT, 0, 0, 16'h8001, 0, 0, 1, 0, 0, 16'h8001));
        dir.push_back(row(REQ_LD_INPUT, 256, 0, 1, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_WR_MULTI, 10, 3, 16'h1111, 0, 0, 0, 0, 0, 0));
        dir.push_back(row(REQ_WR_MULTI, 10, 3, 16'h2222, 5, 0, 0, 0, 0, 0));
        dir.push_back(row(REQ_WR_MULTI, 10, 3, 16'h3333, 2, 1, 1, 0, 10, 3));
        dir.push_back(row(REQ_WR_MULTI, 250, 7, 16'h4444, 127, 1, 1, 1, 0, 0));
        dir.push_back(row(4'd15, 0, 0, 0, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_RD_COILS, 0, 1024, 0, 0, 0, 1, 1, 0, 0));
        dir.push_back(row(REQ_RD_COILS, 1, 512, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(row(REQ_RD_DISCRETE, 0, 3, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(row(REQ_RD_HOLDING, 192, 64, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(row(REQ_RD_INPUT, 0, 1, 0, 0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dir[i])
            send_checked(dir[i]);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 16 : (phase == 1) ? 85 : 0;
            recv_idle = (phase == 0) ? 85 : (phase == 1) ? 16 : 0;
            for (int n = 0; n < 45; n++) begin
                if ($urandom_range(3) == 0) begin
                    n_multi = $urandom_range(1, 6);
                    base = $urandom_range(256 - n_multi);
                    for (int e = 0; e < n_multi; e++) begin
                        r = random_request();
                        r.kind = REQ_WR_MULTI;
                        r.addr = 16'(base);
                        r.qty = 16'(n_multi);
                        r.idx = 7'(e);
                        r.fin = (e == n_multi - 1);
                        send_request(r);
                    end
                end else begin
                    send_request(random_request());
                end
            end
        end
        s_valid <= 1'b0;
        recv_idle = 0;
        while (pending_resp.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d requests covering reads, writes, loads and range errors;",
                 req_count);
        $display("checked %0d response items against the table model.", resp_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
